/* rtl/core/ndd_pkg.sv */
// ----------------------------------------------------------------------------
// ndd_pkg
// Shared types, codes and fixed-point helpers for the Newton interpolator.
// ----------------------------------------------------------------------------
package ndd_pkg;

    // default capacity of the sample set
    localparam int DEF_MAX_POINTS = 16;

    // opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_EVAL  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_DUP   = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic [1:0]         status;
    } t_out_item;

    // request to the shared divider
    typedef struct packed {
        logic               start;
        logic signed [32:0] num;
        logic signed [32:0] den;
    } t_div_req;

    // answer from the shared divider
    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
        logic               sat;
    } t_div_rsp;

    // saturated value with flag
    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } t_sat;

    // clamp a 33-bit sum or difference to 32 bits
    function automatic t_sat f_clamp33(input logic signed [32:0] v);
        t_sat r;
        if (v[32] != v[31]) begin
            r.sat = 1'b1;
            r.val = v[32] ? Q_MIN : Q_MAX;
        end else begin
            r.sat = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

    // product / 2^24, truncated toward zero, then clamped
    function automatic t_sat f_qscale(input logic signed [63:0] p);
        t_sat               r;
        logic signed [63:0] adj;
        logic [39:0]        t;
        adj = p[63] ? (p + 64'sd16777215) : p;
        t   = adj[63:24];
        if ((&t[39:31]) || !(|t[39:31])) begin
            r.sat = 1'b0;
            r.val = t[31:0];
        end else begin
            r.sat = 1'b1;
            r.val = t[39] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

endpackage

/* rtl/core/ndd_div.sv */
// ----------------------------------------------------------------------------
// ndd_div
// Radix-2 restoring divider: (num * 2^24) / den, truncated toward zero,
// saturated to 32 bits; a zero divisor gives zero. One quotient bit a cycle.
// ----------------------------------------------------------------------------
module ndd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ndd_pkg::t_div_req i_req,
    output ndd_pkg::t_div_rsp o_rsp
);
    import ndd_pkg::*;

    localparam int QW = 57;
    localparam logic [5:0] LAST_STEP = 6'(QW - 1);

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic [32:0]       r_rem;
    logic [QW-1:0]     r_quo;
    logic [32:0]       r_dmag;
    logic              r_neg;
    logic              r_zero;

    logic [32:0]       num_mag;
    logic [32:0]       den_mag;
    logic [33:0]       rem_sh;
    logic [33:0]       trial;

    // operand magnitudes and one trial subtraction
    always_comb begin
        num_mag = i_req.num[32] ? (~i_req.num + 33'd1) : i_req.num;
        den_mag = i_req.den[32] ? (~i_req.den + 33'd1) : i_req.den;
        rem_sh  = {r_rem, r_quo[QW-1]};
        trial   = rem_sh - {1'b0, r_dmag};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quo  <= {num_mag, 24'd0};
            r_dmag <= den_mag;
            r_neg  <= i_req.num[32] ^ i_req.den[32];
            r_zero <= (i_req.den == '0);
        end else if (r_busy) begin
            if (!trial[33]) begin
                r_rem <= trial[32:0];
                r_quo <= {r_quo[QW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[32:0];
                r_quo <= {r_quo[QW-2:0], 1'b0};
            end
        end
    end

    // sign and saturation of the result
    always_comb begin
        o_rsp.done = r_done;
        o_rsp.sat  = 1'b0;
        o_rsp.quo  = '0;
        if (!r_zero) begin
            if (!r_neg) begin
                if (|r_quo[QW-1:31]) begin
                    o_rsp.sat = 1'b1;
                    o_rsp.quo = Q_MAX;
                end else begin
                    o_rsp.quo = r_quo[31:0];
                end
            end else begin
                if ((|r_quo[QW-1:32]) || (r_quo[31] && (|r_quo[30:0]))) begin
                    o_rsp.sat = 1'b1;
                    o_rsp.quo = Q_MIN;
                end else begin
                    o_rsp.quo = ~r_quo[31:0] + 32'd1;
                end
            end
        end
    end

endmodule

/* rtl/core/newton_divided_difference_interp.sv */
// ----------------------------------------------------------------------------
// newton_divided_difference_interp
// Newton divided-difference interpolator in signed Q8.24, one shared divider
// and one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | signals                            | carries
//  ---------+-----------+------------------------------------+-------------------
//  in       | input     | i_in_valid, o_in_stall, i_in_data  | opcode, x, y
//  out      | output    | o_out_valid, i_out_stall, o_out_data | value, status
//
//  A load into a set without coefficients and a clear are done in the idle
//  state. A load after the coefficients exist runs n divisions and then a
//  write. An evaluation runs a pairwise duplicate search over the n points,
//  n(n-1)/2 divisions when the table is rebuilt, and a multiply and
//  accumulate over the terms.
//  Reset clears the point count and the coefficient flag; the stores hold.
//  A stalled result waits in the output register while new items are taken.
// ----------------------------------------------------------------------------
module newton_divided_difference_interp #(
    parameter int MAX_POINTS = ndd_pkg::DEF_MAX_POINTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ndd_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ndd_pkg::t_out_item o_out_data
);
    import ndd_pkg::*;

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    // sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_EX_RD   = 5'd1;
    localparam logic [4:0] S_EX_DIV  = 5'd2;
    localparam logic [4:0] S_EX_WAIT = 5'd3;
    localparam logic [4:0] S_EX_WR   = 5'd4;
    localparam logic [4:0] S_DUP_RI  = 5'd5;
    localparam logic [4:0] S_DUP_LI  = 5'd6;
    localparam logic [4:0] S_DUP_RJ  = 5'd7;
    localparam logic [4:0] S_DUP_CMP = 5'd8;
    localparam logic [4:0] S_B_R1    = 5'd9;
    localparam logic [4:0] S_B_R2    = 5'd10;
    localparam logic [4:0] S_B_DIV   = 5'd11;
    localparam logic [4:0] S_B_WAIT  = 5'd12;
    localparam logic [4:0] S_E_RD    = 5'd13;
    localparam logic [4:0] S_E_LD    = 5'd14;
    localparam logic [4:0] S_E_MUL   = 5'd15;
    localparam logic [4:0] S_E_SC    = 5'd16;
    localparam logic [4:0] S_E_ADD   = 5'd17;
    localparam logic [4:0] S_OUT     = 5'd18;

    // control registers
    logic [4:0]         r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_cv, n_cv;
    logic [IW-1:0]      r_i, n_i;
    logic [IW-1:0]      r_j, n_j;
    logic               r_sat, n_sat;
    logic               r_ov, n_ov;

    // payload registers
    logic signed [31:0] r_x, n_x;
    logic signed [31:0] r_t, n_t;
    logic signed [31:0] r_acc, n_acc;
    logic signed [31:0] r_ai, n_ai;
    logic signed [31:0] r_di, n_di;
    logic signed [63:0] r_prod, n_prod;
    t_out_item          r_res, n_res;
    t_out_item          r_out, n_out;

    // stores
    logic signed [31:0] mem_a [MAX_POINTS];
    logic signed [31:0] mem_d [MAX_POINTS];
    logic signed [31:0] r_a_q;
    logic signed [31:0] r_d_q;
    logic [IW-1:0]      a_raddr, d_raddr, waddr;
    logic               a_we, d_we;
    logic signed [31:0] a_wdata, d_wdata;

    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic               full;
    logic               out_free;
    logic [CW-1:0]      last_idx;
    t_sat               cl;
    t_sat               sc;
    logic signed [31:0] dval;
    logic               sat_new;

    ndd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // stores: one write, one registered read each
    always_ff @(posedge i_clk) begin
        if (a_we) begin
            mem_a[waddr] <= a_wdata;
        end
        if (d_we) begin
            mem_d[waddr] <= d_wdata;
        end
        r_a_q <= mem_a[a_raddr];
        r_d_q <= mem_d[d_raddr];
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign full        = (r_cnt == CW'(MAX_POINTS));
    assign out_free    = !r_ov || !i_out_stall;
    assign last_idx    = r_cnt - CW'(1);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_cv    = r_cv;
        n_i     = r_i;
        n_j     = r_j;
        n_sat   = r_sat;
        n_x     = r_x;
        n_t     = r_t;
        n_acc   = r_acc;
        n_ai    = r_ai;
        n_di    = r_di;
        n_prod  = r_prod;
        n_res   = r_res;
        n_ov    = r_ov;
        n_out   = r_out;
        a_raddr = r_i;
        d_raddr = r_i;
        waddr   = r_cnt[IW-1:0];
        a_we    = 1'b0;
        d_we    = 1'b0;
        a_wdata = r_x;
        d_wdata = r_t;
        div_req = '0;
        cl      = f_clamp33('0);
        sc      = f_qscale(r_prod);
        dval    = '0;
        sat_new = r_sat;

        // output register drains on a transfer
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_x = i_in_data.x_value;
                    case (i_in_data.opcode)
                        OP_LOAD: begin
                            if (!full) begin
                                if (r_cv) begin
                                    n_t     = i_in_data.y_value;
                                    n_i     = '0;
                                    n_state = S_EX_RD;
                                end else begin
                                    a_we    = 1'b1;
                                    d_we    = 1'b1;
                                    a_wdata = i_in_data.x_value;
                                    d_wdata = i_in_data.y_value;
                                    n_cnt   = r_cnt + CW'(1);
                                end
                            end
                        end
                        OP_EVAL: begin
                            n_sat = 1'b0;
                            n_acc = '0;
                            n_i   = '0;
                            n_j   = '0;
                            if (r_cnt == '0) begin
                                n_res.interp_value = '0;
                                n_res.status       = ST_EMPTY;
                                n_state            = S_OUT;
                            end else if (r_cnt == CW'(1)) begin
                                n_cv    = 1'b1;
                                n_state = S_E_RD;
                            end else begin
                                n_j     = IW'(1);
                                n_state = S_DUP_RI;
                            end
                        end
                        OP_CLEAR: begin
                            n_cnt = '0;
                            n_cv  = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end

            // extend the coefficients by one new point
            S_EX_RD: begin
                n_state = S_EX_DIV;
            end
            S_EX_DIV: begin
                div_req.start = 1'b1;
                div_req.num   = {r_t[31], r_t} - {r_d_q[31], r_d_q};
                div_req.den   = {r_x[31], r_x} - {r_a_q[31], r_a_q};
                n_state       = S_EX_WAIT;
            end
            S_EX_WAIT: begin
                if (div_rsp.done) begin
                    n_t = div_rsp.quo;
                    n_i = r_i + IW'(1);
                    if (CW'(r_i) + CW'(1) == r_cnt) begin
                        n_state = S_EX_WR;
                    end else begin
                        n_state = S_EX_RD;
                    end
                end
            end
            S_EX_WR: begin
                a_we    = 1'b1;
                d_we    = 1'b1;
                n_cnt   = r_cnt + CW'(1);
                n_state = S_IDLE;
            end

            // pairwise search for a repeated abscissa
            S_DUP_RI: begin
                n_state = S_DUP_LI;
            end
            S_DUP_LI: begin
                n_ai    = r_a_q;
                a_raddr = r_j;
                n_state = S_DUP_CMP;
            end
            S_DUP_RJ: begin
                a_raddr = r_j;
                n_state = S_DUP_CMP;
            end
            S_DUP_CMP: begin
                if (r_a_q == r_ai) begin
                    n_res.interp_value = '0;
                    n_res.status       = ST_DUP;
                    n_state            = S_OUT;
                end else if (CW'(r_j) + CW'(1) < r_cnt) begin
                    n_j     = r_j + IW'(1);
                    n_state = S_DUP_RJ;
                end else if (CW'(r_i) + CW'(2) < r_cnt) begin
                    n_i     = r_i + IW'(1);
                    n_j     = r_i + IW'(2);
                    n_state = S_DUP_RI;
                end else if (r_cv) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = S_E_RD;
                end else begin
                    n_i     = last_idx[IW-1:0];
                    n_j     = IW'(1);
                    n_state = S_B_R1;
                end
            end

            // divided-difference table, built in place
            S_B_R1: begin
                n_state = S_B_R2;
            end
            S_B_R2: begin
                n_di    = r_d_q;
                n_ai    = r_a_q;
                d_raddr = r_i - IW'(1);
                a_raddr = r_i - r_j;
                n_state = S_B_DIV;
            end
            S_B_DIV: begin
                div_req.start = 1'b1;
                div_req.num   = {r_di[31], r_di} - {r_d_q[31], r_d_q};
                div_req.den   = {r_ai[31], r_ai} - {r_a_q[31], r_a_q};
                n_state       = S_B_WAIT;
            end
            S_B_WAIT: begin
                if (div_rsp.done) begin
                    d_we    = 1'b1;
                    waddr   = r_i;
                    d_wdata = div_rsp.quo;
                    n_sat   = r_sat | div_rsp.sat;
                    if (r_i > r_j) begin
                        n_i     = r_i - IW'(1);
                        n_state = S_B_R1;
                    end else if (CW'(r_j) + CW'(1) < r_cnt) begin
                        n_j     = r_j + IW'(1);
                        n_i     = last_idx[IW-1:0];
                        n_state = S_B_R1;
                    end else begin
                        n_cv    = 1'b1;
                        n_i     = '0;
                        n_j     = '0;
                        n_state = S_E_RD;
                    end
                end
            end

            // evaluation: term j is coef[j] times the product of (x - x_i)
            S_E_RD: begin
                d_raddr = r_j;
                n_state = S_E_LD;
            end
            S_E_LD: begin
                n_t     = r_d_q;
                n_i     = '0;
                a_raddr = '0;
                if (r_j == '0) begin
                    n_state = S_E_ADD;
                end else begin
                    n_state = S_E_MUL;
                end
            end
            S_E_MUL: begin
                cl      = f_clamp33({r_x[31], r_x} - {r_a_q[31], r_a_q});
                dval    = cl.val;
                n_sat   = r_sat | cl.sat;
                n_prod  = r_t * dval;
                n_state = S_E_SC;
            end
            S_E_SC: begin
                n_t     = sc.val;
                n_sat   = r_sat | sc.sat;
                n_i     = r_i + IW'(1);
                a_raddr = r_i + IW'(1);
                if (r_i + IW'(1) == r_j) begin
                    n_state = S_E_ADD;
                end else begin
                    n_state = S_E_MUL;
                end
            end
            S_E_ADD: begin
                cl      = f_clamp33({r_acc[31], r_acc} + {r_t[31], r_t});
                n_acc   = cl.val;
                sat_new = r_sat | cl.sat;
                n_sat   = sat_new;
                if (CW'(r_j) + CW'(1) < r_cnt) begin
                    n_j     = r_j + IW'(1);
                    n_state = S_E_RD;
                end else begin
                    n_res.interp_value = cl.val;
                    n_res.status       = sat_new ? ST_SAT : ST_OK;
                    n_state            = S_OUT;
                end
            end

            // hand the result to the output register
            S_OUT: begin
                if (out_free) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_cv    <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_sat   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_cv    <= n_cv;
            r_i     <= n_i;
            r_j     <= n_j;
            r_sat   <= n_sat;
            r_ov    <= n_ov;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_t    <= n_t;
        r_acc  <= n_acc;
        r_ai   <= n_ai;
        r_di   <= n_di;
        r_prod <= n_prod;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_div_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_EX_WAIT || r_state == S_B_WAIT))
        else $error("divider answer with no step waiting");

    a_eval_has_coef: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_E_RD) |-> r_cv)
        else $error("evaluation without coefficients");

    a_extend_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EX_RD) |-> (r_cnt != '0 && !full))
        else $error("coefficient extension on empty or full set");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Newton divided-difference interpolator: loads,
// clears and evaluations are streamed in with random gaps, every evaluation is
// predicted by an in-bench fixed-point model, and each transfer on the result
// channel is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import ndd_pkg::*;

    localparam int         NPTS       = DEF_MAX_POINTS;
    localparam logic [1:0] OP_NOP     = 2'd3;
    localparam int         IDLE_LIMIT = 40000;
    localparam int         TAIL_WAIT  = 3000;
    localparam int         NUM_ITEMS  = 800;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    // pending stimulus and expected results
    t_in_item  pend_q[$];
    bit        drain_q[$];
    t_out_item interp_q[$];

    // interpolator shadow state
    int          x_store[NPTS];
    int          coef[NPTS];
    int unsigned npts_loaded = 0;
    bit          coef_ok = 1'b0;

    int fails = 0;
    int in_gap = 0;
    int out_hold = 0;
    bit no_idle = 1'b0;
    int idle_cycles = 0;

    newton_divided_difference_interp u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // saturate to 32 bits
    function automatic int sat32(input longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    // (num * 2^24) / den, zero divisor gives zero
    function automatic int q_quot(input longint num, input longint den, inout bit sat);
        if (den == 0)
            return 0;
        return sat32((num * 64'sd16777216) / den, sat);
    endfunction

    function automatic int q_prod(input int a, input int b, inout bit sat);
        longint p;
        p = longint'(a) * longint'(b);
        return sat32(p / 64'sd16777216, sat);
    endfunction

    // advance the shadow state by one accepted item
    task automatic interp_predict(input t_in_item it);
        bit        sat;
        bit        dup;
        int        t;
        int        part;
        int        d;
        int        acc;
        t_out_item r;
        sat = 1'b0;
        dup = 1'b0;
        acc = 0;
        case (it.opcode)
            OP_LOAD: begin
                if (npts_loaded < NPTS) begin
                    t = it.y_value;
                    if (coef_ok) begin
                        for (int k = 1; k <= npts_loaded; k++)
                            t = q_quot(longint'(t) - coef[k-1],
                                       longint'(it.x_value) - x_store[k-1], sat);
                    end
                    coef[npts_loaded] = t;
                    x_store[npts_loaded] = it.x_value;
                    npts_loaded++;
                end
            end
            OP_CLEAR: begin
                npts_loaded = 0;
                coef_ok = 1'b0;
            end
            OP_EVAL: begin
                r.interp_value = '0;
                if (npts_loaded == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < npts_loaded; i++)
                        for (int j = i + 1; j < npts_loaded; j++)
                            if (x_store[i] == x_store[j])
                                dup = 1'b1;
                    if (dup) begin
                        r.status = ST_DUP;
                    end else begin
                        // in-place divided-difference table
                        if (!coef_ok) begin
                            for (int j = 1; j < npts_loaded; j++)
                                for (int i = npts_loaded - 1; i >= j; i--)
                                    coef[i] = q_quot(longint'(coef[i]) - coef[i-1],
                                                     longint'(x_store[i]) - x_store[i-j],
                                                     sat);
                            coef_ok = 1'b1;
                        end
                        for (int k = 0; k < npts_loaded; k++) begin
                            part = coef[k];
                            for (int i = 0; i < k; i++) begin
                                d = sat32(longint'(it.x_value) - x_store[i], sat);
                                part = q_prod(part, d, sat);
                            end
                            acc = sat32(longint'(acc) + part, sat);
                        end
                        r.interp_value = acc;
                        r.status = sat ? ST_SAT : ST_OK;
                    end
                end
                interp_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    // input driver
    always @(posedge i_clk) begin
        bit busy;
        busy = 1'b0;
        if (i_rst_n) begin
            if (in_valid && !in_stall)
                interp_predict(in_data);
            else if (in_valid)
                busy = 1'b1;
            if (!busy) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (pend_q.size() > 0 && !(drain_q[0] && interp_q.size() > 0)) begin
                    in_data <= pend_q.pop_front();
                    void'(drain_q.pop_front());
                    in_valid <= 1'b1;
                    if (($urandom % 64) == 0)
                        no_idle <= !no_idle;
                    in_gap <= no_idle ? 0 : $urandom_range(0, 5);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                if (interp_q.size() == 0) begin
                    $display("%0t: unexpected result value=%h status=%0d", $time,
                             out_data.interp_value, out_data.status);
                    fails++;
                end else begin
                    exp_r = interp_q.pop_front();
                    if (out_data.interp_value !== exp_r.interp_value) begin
                        $display("%0t: interp_value expected %h actual %h", $time,
                                 exp_r.interp_value, out_data.interp_value);
                        fails++;
                    end
                    if (out_data.status !== exp_r.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_r.status, out_data.status);
                        fails++;
                    end
                end
                out_hold = no_idle ? 0 : $urandom_range(0, 5);
            end else if (out_hold > 0) begin
                out_hold--;
            end
            out_stall <= (out_hold > 0);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_item(input logic [1:0] op, input int x, input int y);
        t_in_item it;
        it.opcode  = op;
        it.x_value = x;
        it.y_value = y;
        pend_q.push_back(it);
        drain_q.push_back(1'b0);
    endtask

    // mostly values within plus or minus 8.0 in Q8.24, sometimes any 32-bit pattern
    function automatic int rand_q();
        if (($urandom % 4) == 0)
            return int'($urandom);
        return int'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
    endfunction

    // stimulus and end of run
    initial begin
        int n;
        int xs[$];

        // directed part
        add_item(OP_EVAL, 32'sh01000000, 0);
        add_item(OP_CLEAR, int'($urandom), int'($urandom));
        add_item(OP_LOAD, 32'sh80000000, 32'sh7fffffff);
        add_item(OP_LOAD, 32'sh7fffffff, 32'sh80000000);
        add_item(OP_EVAL, 0, 0);
        add_item(OP_EVAL, 32'sh7fffffff, 0);
        add_item(OP_LOAD, 0, 0);
        add_item(OP_EVAL, 32'sh80000000, 0);
        add_item(OP_LOAD, 32'sh7fffffff, 32'sh01000000);
        add_item(OP_EVAL, 32'sh00800000, 0);
        add_item(OP_NOP, int'($urandom), int'($urandom));
        add_item(OP_CLEAR, 0, 0);
        add_item(OP_LOAD, 32'sh00000000, 32'sh01000000);
        add_item(OP_LOAD, 32'sh01000000, 32'sh02000000);
        add_item(OP_LOAD, 32'sh02000000, 32'sh05000000);
        add_item(OP_EVAL, 32'sh01800000, 0);
        add_item(OP_EVAL, 32'sh80000000, 0);
        add_item(OP_LOAD, 32'shff000000, 32'sh00000000);
        add_item(OP_EVAL, 32'sh00400000, 0);

        // random sample sets with evaluations
        while (pend_q.size() < NUM_ITEMS) begin
            add_item(OP_CLEAR, int'($urandom), int'($urandom));
            n = (($urandom % 12) == 0) ? NPTS : $urandom_range(1, 6);
            xs.delete();
            for (int i = 0; i < n; i++) begin
                if (i > 0 && ($urandom % 25) == 0)
                    xs.push_back(xs[$urandom_range(0, i - 1)]);
                else
                    xs.push_back(rand_q());
                add_item(OP_LOAD, xs[i], rand_q());
            end
            if (n == NPTS && ($urandom % 2) == 0)
                add_item(OP_LOAD, rand_q(), rand_q());
            for (int e = $urandom_range(1, 3); e > 0; e--)
                add_item(OP_EVAL, rand_q(), int'($urandom));
            if (n < NPTS - 2 && ($urandom % 2) == 0) begin
                for (int e = $urandom_range(1, 2); e > 0; e--)
                    add_item(OP_LOAD, rand_q(), rand_q());
                add_item(OP_EVAL, rand_q(), int'($urandom));
            end
            if (($urandom % 8) == 0)
                add_item(OP_NOP, int'($urandom), int'($urandom));
            if (pend_q.size() > NUM_ITEMS / 2 && pend_q.size() < NUM_ITEMS / 2 + 40)
                drain_q[pend_q.size() - 1] = 1'b1;
        end

        // reset
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for everything to be sent and answered
        while (pend_q.size() > 0 || in_valid || interp_q.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/core/ndd_pkg.sv
rtl/core/ndd_div.sv
rtl/core/newton_divided_difference_interp.sv
bench/tb_top.sv
